// ===== rtl/izt_pkg.sv =====
// shared types, constants and helpers of the zupt step tracker
// used by izt_div and imu_step_zupt_tracker_core
package izt_pkg;

  localparam int DIV_W = 52;
  localparam int MA_W  = 37;
  localparam int MB_W  = 21;
  localparam int PR_W  = MA_W + MB_W;

  localparam logic [19:0] GRAV_Q16  = 20'd642908;
  localparam logic [19:0] US_PER_S  = 20'd1000000;
  localparam logic [12:0] ONE_G_RAW = 13'd4096;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  localparam logic [1:0] REG_ACCEL_THR  = 2'd0;
  localparam logic [1:0] REG_GYRO_THR   = 2'd1;
  localparam logic [1:0] REG_PERIOD     = 2'd2;
  localparam logic [1:0] REG_SETTLE     = 2'd3;

  localparam logic [2:0] PH_STANCE = 3'd0;
  localparam logic [2:0] PH_PEAK   = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_TROUGH = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAG, ST_ROT, ST_VEL, ST_DIV, ST_POS, ST_FIN
  } state_t;

  typedef struct packed {
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic [31:0]        time_us;
  } sample_t;

  typedef struct packed {
    logic               is_stationary;
    logic               contact_event;
    logic               lift_event;
    logic [2:0]         vertical_phase;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/izt_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
// depends on izt_pkg for widths
module izt_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [izt_pkg::DIV_W-1:0]  dividend,
  input  logic [31:0]                divisor,
  output logic                       done,
  output logic [izt_pkg::DIV_W-1:0]  quotient
);
  import izt_pkg::*;

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;

  assign rem_sh  = {rem, quotient[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      if (!rem_sub[32]) begin
        rem      <= rem_sub[31:0];
        quotient <= {quotient[DIV_W-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[31:0];
        quotient <= {quotient[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/imu_step_zupt_tracker_core.sv =====
// foot-mounted imu tracker: stance detection, world-frame velocity and position, vertical phase
// depends on izt_pkg and izt_div
// One sample runs from transfer to result through a single shared 37x21 multiplier stepped by
// the sequencer; the next sample is taken only once the previous sequence is complete. On the
// first stationary sample after motion with a nonzero elapsed time, the drift-rate update adds
// three division passes, one per axis, each producing a 52-bit quotient.
// Input is taken only while idle. The result sits in an output register so the next sample can
// be taken before it is collected; a sample finishing while that register is still full waits.
module imu_step_zupt_tracker_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  izt_pkg::sample_t  sample,
  output logic              result_valid,
  input  logic              result_ready,
  output izt_pkg::result_t  result,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import izt_pkg::*;

  state_t state, state_next;
  logic [3:0] step, step_next;
  logic [1:0] axis, axis_next;

  logic [15:0] accel_thr, gyro_thr, dt, settle_limit;

  logic signed [15:0] g [3];
  logic signed [15:0] a [3];
  logic signed [16:0] u [3];
  logic signed [15:0] qw;
  logic [31:0]        now;

  logic               stance, still, contact, lift, pending;
  logic [31:0]        lift_time;
  logic signed [31:0] prev_lin [3];
  logic signed [31:0] lin [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] oldv [3];
  logic signed [31:0] drift [3];
  logic signed [31:0] pos [3];
  logic [2:0]         phase;
  logic signed [31:0] ext;
  logic [15:0]        sc;

  logic signed [63:0] acc;
  logic [34:0]        sg, sa, hisq, losq;
  logic signed [33:0] t [3];
  logic signed [36:0] accv;
  logic signed [33:0] dd;

  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [PR_W-1:0] prod;
  logic signed [63:0]     p64, diff, rnd16, rnd17, vsum, q64, psum64;
  logic signed [32:0]     sum_pl, psum;
  logic [16:0]            hi;
  logic signed [17:0]     lo;
  logic [31:0]            el;
  logic                   go_div, out_free, still_now;

  logic                   div_start, div_done, div_neg;
  logic [DIV_W-1:0]       div_quo;
  logic [PR_W-1:0]        prod_mag;

  logic [2:0]             ph_n;
  logic signed [31:0]     ext_n, vz;
  logic [15:0]            sc_n, sc_inc;
  logic                   clear_pos;

  assign sample_ready = (state == ST_IDLE);
  assign hi     = 17'(ONE_G_RAW) + 17'(accel_thr);
  assign lo     = 18'(ONE_G_RAW) - 18'(accel_thr);
  assign el     = now - lift_time;
  assign go_div = still && pending && (el != 32'd0);
  assign out_free = !result_valid || result_ready;
  assign p64    = 64'(prod);
  assign diff   = acc - p64;
  assign rnd16  = (p64 + 64'sd32768) >>> 16;
  assign rnd17  = (p64 + 64'sd65536) >>> 17;
  assign sum_pl = 33'(prev_lin[axis]) + 33'(lin[axis]);
  assign psum   = 33'(oldv[axis]) + 33'(vel[axis]);
  assign vsum   = 64'(vel[axis]) + rnd16 - 64'(dd);
  assign psum64 = 64'(pos[axis]) + rnd17;
  assign prod_mag = prod[PR_W-1] ? PR_W'(-prod) : PR_W'(prod);
  assign div_start = (state == ST_DIV) && (step == 4'd1);
  assign still_now = (sa < hisq) && (lo[17] || (sa > losq)) && (sg < prod[34:0]);
  assign vz = vel[2];
  assign clear_pos = still || pos[2][31];

  always_comb begin
    q64 = $signed(64'(div_quo));
    if (div_neg) q64 = -q64;
  end

  izt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_mag[DIV_W-1:0]),
    .divisor  (el),
    .done     (div_done),
    .quotient (div_quo)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MAG: begin
        case (step)
          4'd0: begin mul_a = 37'(g[0]); mul_b = 21'(g[0]); end
          4'd1: begin mul_a = 37'(g[1]); mul_b = 21'(g[1]); end
          4'd2: begin mul_a = 37'(g[2]); mul_b = 21'(g[2]); end
          4'd3: begin mul_a = 37'(a[0]); mul_b = 21'(a[0]); end
          4'd4: begin mul_a = 37'(a[1]); mul_b = 21'(a[1]); end
          4'd5: begin mul_a = 37'(a[2]); mul_b = 21'(a[2]); end
          4'd6: begin mul_a = 37'(hi); mul_b = 21'(hi); end
          4'd7: begin mul_a = 37'(lo); mul_b = 21'(lo); end
          4'd8: begin mul_a = 37'(gyro_thr); mul_b = 21'(gyro_thr); end
          default: ;
        endcase
      end
      ST_ROT: begin
        case (step)
          4'd0:  begin mul_a = 37'(a[2]); mul_b = 21'(u[1]); end
          4'd1:  begin mul_a = 37'(a[1]); mul_b = 21'(u[2]); end
          4'd2:  begin mul_a = 37'(a[0]); mul_b = 21'(u[2]); end
          4'd3:  begin mul_a = 37'(a[2]); mul_b = 21'(u[0]); end
          4'd4:  begin mul_a = 37'(a[1]); mul_b = 21'(u[0]); end
          4'd5:  begin mul_a = 37'(a[0]); mul_b = 21'(u[1]); end
          4'd6:  begin mul_a = 37'(t[0]); mul_b = 21'(qw); end
          4'd7:  begin mul_a = 37'(t[2]); mul_b = 21'(u[1]); end
          4'd8:  begin mul_a = 37'(t[1]); mul_b = 21'(u[2]); end
          4'd9:  begin mul_a = 37'(t[1]); mul_b = 21'(qw); end
          4'd10: begin mul_a = 37'(t[0]); mul_b = 21'(u[2]); end
          4'd11: begin mul_a = 37'(t[2]); mul_b = 21'(u[0]); end
          4'd12: begin mul_a = 37'(t[2]); mul_b = 21'(qw); end
          4'd13: begin mul_a = 37'(t[1]); mul_b = 21'(u[0]); end
          4'd14: begin mul_a = 37'(t[0]); mul_b = 21'(u[1]); end
          default: ;
        endcase
      end
      ST_VEL: begin
        case (step)
          4'd0: begin mul_a = 37'(sum_pl); mul_b = 21'(GRAV_Q16); end
          4'd1: begin mul_a = 37'(drift[axis]); mul_b = 21'(dt); end
          4'd2: begin mul_a = accv; mul_b = 21'(dt); end
          default: ;
        endcase
      end
      ST_DIV: begin
        mul_a = 37'(vel[axis]);
        mul_b = 21'(US_PER_S);
      end
      ST_POS: begin
        mul_a = 37'(psum);
        mul_b = 21'(dt);
      end
      ST_IDLE, ST_FIN: ;
      default: ;
    endcase
  end

  // vertical velocity phase
  always_comb begin
    ph_n   = phase;
    ext_n  = ext;
    sc_n   = sc;
    sc_inc = sc;
    if (still) begin
      ph_n = PH_STANCE;
    end else begin
      case (phase) inside
        PH_STANCE: begin
          ph_n  = PH_PEAK;
          ext_n = -ONE_Q16;
          sc_n  = '0;
        end
        PH_PEAK, PH_TROUGH: begin
          if ((phase == PH_PEAK && ext < vz) || (phase == PH_TROUGH && ext > vz)) begin
            ext_n  = vz;
            sc_inc = '0;
          end else if (sc != 16'hffff) begin
            sc_inc = sc + 16'd1;
          end
          sc_n = sc_inc;
          if (sc_inc > settle_limit) begin
            ext_n = '0;
            sc_n  = '0;
            ph_n  = (phase == PH_PEAK) ? PH_ZERO : PH_DONE;
          end
        end
        PH_ZERO: begin
          if (vz < ext && sc != 16'hffff) sc_inc = sc + 16'd1;
          sc_n = sc_inc;
          if (sc_inc > settle_limit) begin
            ph_n  = PH_TROUGH;
            ext_n = ONE_Q16;
            sc_n  = '0;
          end
        end
        default: ph_n = PH_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      axis  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      axis  <= axis_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step + 4'd1;
    axis_next  = axis;
    unique case (state)
      ST_IDLE: begin
        step_next = '0;
        axis_next = '0;
        if (sample_valid) state_next = ST_MAG;
      end
      ST_MAG: begin
        if (step == 4'd9) begin
          state_next = ST_ROT;
          step_next  = '0;
        end
      end
      ST_ROT: begin
        if (step == 4'd15) begin
          state_next = ST_VEL;
          step_next  = '0;
          axis_next  = '0;
        end
      end
      ST_VEL: begin
        if (step == 4'd3) begin
          step_next = '0;
          if (axis == 2'd2) begin
            axis_next  = '0;
            state_next = go_div ? ST_DIV : ST_POS;
          end else begin
            axis_next = axis + 2'd1;
          end
        end
      end
      ST_DIV: begin
        if (step == 4'd2) begin
          step_next = step;
          if (div_done) begin
            step_next = '0;
            if (axis == 2'd2) begin
              axis_next  = '0;
              state_next = ST_POS;
            end else begin
              axis_next = axis + 2'd1;
            end
          end
        end
      end
      ST_POS: begin
        if (step == 4'd1) begin
          step_next = '0;
          if (axis == 2'd2) state_next = ST_FIN;
          else axis_next = axis + 2'd1;
        end
      end
      ST_FIN: begin
        step_next = '0;
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_thr    <= 16'd410;
      gyro_thr     <= 16'd800;
      dt           <= 16'd655;
      settle_limit <= 16'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACCEL_THR: accel_thr    <= cfg_data;
        REG_GYRO_THR:  gyro_thr     <= cfg_data;
        REG_PERIOD:    dt           <= cfg_data;
        REG_SETTLE:    settle_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample latch and scratch registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && sample_valid) begin
      g[0] <= sample.gyro_x;
      g[1] <= sample.gyro_y;
      g[2] <= sample.gyro_z;
      a[0] <= sample.accel_x;
      a[1] <= sample.accel_y;
      a[2] <= sample.accel_z;
      qw   <= sample.quat_w;
      u[0] <= -17'(sample.quat_x);
      u[1] <= -17'(sample.quat_y);
      u[2] <= -17'(sample.quat_z);
      now  <= sample.time_us;
    end
    if (state == ST_MAG) begin
      case (step)
        4'd1: acc <= p64;
        4'd2: acc <= acc + p64;
        4'd3: sg <= 35'(acc + p64);
        4'd4: acc <= p64;
        4'd5: acc <= acc + p64;
        4'd6: sa <= 35'(acc + p64);
        4'd7: hisq <= prod[34:0];
        4'd8: losq <= prod[34:0];
        default: ;
      endcase
    end
    if (state == ST_ROT) begin
      case (step)
        4'd1, 4'd3, 4'd5: acc <= p64;
        4'd2:  t[0] <= 34'(diff <<< 1);
        4'd4:  t[1] <= 34'(diff <<< 1);
        4'd6:  t[2] <= 34'(diff <<< 1);
        4'd7:  acc <= (64'(a[0]) <<< 28) + p64;
        4'd8, 4'd11, 4'd14: acc <= acc + p64;
        4'd9:  lin[0] <= sat32((diff + 64'sd8388608) >>> 24);
        4'd10: acc <= (64'(a[1]) <<< 28) + p64;
        4'd12: lin[1] <= sat32((diff + 64'sd8388608) >>> 24);
        4'd13: acc <= (64'(a[2]) <<< 28) - (64'sd1 <<< 40) + p64;
        4'd15: lin[2] <= sat32((diff + 64'sd8388608) >>> 24);
        default: ;
      endcase
    end
    if (state == ST_VEL) begin
      if (step == 4'd1) accv <= 37'(rnd17);
      if (step == 4'd2) dd <= 34'(rnd16);
    end
    if (div_start) div_neg <= prod[PR_W-1];
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      stance       <= 1'b0;
      still        <= 1'b0;
      contact      <= 1'b0;
      lift         <= 1'b0;
      lift_time    <= '0;
      pending      <= 1'b0;
      phase        <= PH_STANCE;
      ext          <= '0;
      sc           <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        prev_lin[i] <= '0;
        vel[i]      <= '0;
        drift[i]    <= '0;
        pos[i]      <= '0;
      end
    end else begin
      if (result_valid && result_ready && state != ST_FIN) result_valid <= 1'b0;
      if (state == ST_MAG && step == 4'd9) begin
        still   <= still_now;
        contact <= 1'b0;
        lift    <= 1'b0;
        if (still_now && !stance) begin
          stance  <= 1'b1;
          contact <= 1'b1;
        end else if (!still_now && stance) begin
          stance    <= 1'b0;
          lift      <= 1'b1;
          lift_time <= now;
        end
      end
      if (state == ST_VEL && step == 4'd3) begin
        oldv[axis]     <= vel[axis];
        prev_lin[axis] <= lin[axis];
        if (axis == 2'd2) pending <= !still;
        if (axis == 2'd2 && still && !go_div) begin
          for (int i = 0; i < 3; i++) vel[i] <= '0;
        end else begin
          vel[axis] <= sat32(vsum);
        end
      end
      if (state == ST_DIV && step == 4'd2 && div_done) begin
        drift[axis] <= sat32(64'(drift[axis]) + q64);
        if (axis == 2'd2) begin
          for (int i = 0; i < 3; i++) vel[i] <= '0;
        end
      end
      if (state == ST_POS && step == 4'd1) pos[axis] <= sat32(psum64);
      if (state == ST_FIN && out_free) begin
        if (clear_pos) begin
          for (int i = 0; i < 3; i++) pos[i] <= '0;
        end
        phase        <= ph_n;
        ext          <= ext_n;
        sc           <= sc_n;
        result_valid <= 1'b1;
        result.is_stationary  <= still;
        result.contact_event  <= contact;
        result.lift_event     <= lift;
        result.vertical_phase <= ph_n;
        result.vel_x <= vel[0];
        result.vel_y <= vel[1];
        result.vel_z <= vel[2];
        result.pos_x <= clear_pos ? 32'sd0 : pos[0];
        result.pos_y <= clear_pos ? 32'sd0 : pos[1];
        result.pos_z <= clear_pos ? 32'sd0 : pos[2];
      end
    end
  end

  a_events_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.contact_event && result.lift_event))
    else $error("contact and lift on one sample");

  a_contact_still: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.contact_event |-> result.is_stationary)
    else $error("contact without stance");

  a_stance_zeroed: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.is_stationary |->
      result.vertical_phase == PH_STANCE && result.pos_z == 32'sd0 && result.vel_z == 32'sd0)
    else $error("stance result not zeroed");

  a_div_in_seq: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV && step == 4'd2)
    else $error("divider finished outside drift update");

  a_start_seq: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> state == ST_MAG && step == 4'd0)
    else $error("transfer did not start the sequence");

endmodule
